### rtl/core/apsrd_pkg.sv
package apsrd_pkg;

    // Default width of the raw angle sample.
    localparam int SAMPLE_BITS_DEF = 10;

    // Shared serial arithmetic unit widths.
    localparam int ALU_AW  = 64;
    localparam int ALU_BW  = 40;
    localparam int ALU_CW  = 7;
    localparam int ALU_IW  = $clog2(ALU_AW);

    // Configuration register indexes.
    localparam int REG_IW = 4;
    localparam logic [REG_IW-1:0] REG_GAIN_P      = 4'd0;
    localparam logic [REG_IW-1:0] REG_GAIN_I      = 4'd1;
    localparam logic [REG_IW-1:0] REG_GAIN_D      = 4'd2;
    localparam logic [REG_IW-1:0] REG_DRIVE_LIMIT = 4'd3;
    localparam logic [REG_IW-1:0] REG_TRAVEL_MAX  = 4'd4;
    localparam logic [REG_IW-1:0] REG_ZERO_OFFSET = 4'd5;
    localparam logic [REG_IW-1:0] REG_SENSOR_REV  = 4'd6;
    localparam logic [REG_IW-1:0] REG_MOTOR_REV   = 4'd7;

    // Configuration reset values.
    localparam logic [31:0] RST_GAIN_P      = 32'h0001_0000;
    localparam logic [11:0] RST_DRIVE_LIMIT = 12'd1000;
    localparam logic [9:0]  RST_TRAVEL_MAX  = 10'd512;

    // Control constants.
    localparam logic [11:0] DRIVE_FLOOR = 12'd100;
    localparam logic signed [47:0] I_SAT_POS = 48'sd255000000;
    localparam logic signed [47:0] I_SAT_NEG = -48'sd255000000;
    localparam logic [ALU_BW-1:0] I_SCALE = 40'd1000000;
    localparam logic signed [24:0] SI_SAT = 25'sd16711680;
    localparam logic signed [63:0] INT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] INT_MIN = -64'sh0000_8000_0000_0000;
    localparam logic [15:0] FREQ_MIN = 16'd40;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_A,
        S_DIV_B,
        S_SHAPE_MUL,
        S_SHAPE_DIV,
        S_INT_MUL,
        S_SI_DIV,
        S_SD_DIV,
        S_P_MUL,
        S_I_MUL,
        S_D_MUL,
        S_FINISH
    } state_t;

    // Speed limit ramp regions.
    typedef enum logic [1:0] {
        R_LOW,
        R_MID,
        R_TOP,
        R_NONE
    } region_t;

    // Request to the serial unit: multiply a by the low nbits of b, or
    // divide the low nbits of a by b.
    typedef struct packed {
        logic              start;
        logic              is_div;
        logic [ALU_AW-1:0] a;
        logic [ALU_BW-1:0] b;
        logic [ALU_CW-1:0] nbits;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [ALU_AW-1:0] value;
    } alu_rsp_t;

endpackage

### rtl/core/apsrd_tick_if.sv
interface apsrd_tick_if #(
    parameter int SAMPLE_BITS = apsrd_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] angle_sample;
    logic [19:0]            elapsed_us;
    logic signed [10:0]     target_position;
    logic                   drive_enable;
    logic                   smart_move;
    logic signed [12:0]     requested_speed;

    modport source (
        output valid, angle_sample, elapsed_us, target_position,
        output drive_enable, smart_move, requested_speed,
        input  ready
    );
    modport sink (
        input  valid, angle_sample, elapsed_us, target_position,
        input  drive_enable, smart_move, requested_speed,
        output ready
    );
endinterface

### rtl/core/apsrd_result_if.sv
interface apsrd_result_if #(
    parameter int SAMPLE_BITS = apsrd_pkg::SAMPLE_BITS_DEF
);
    logic                     valid;
    logic                     ready;
    logic signed [SAMPLE_BITS:0] position;
    logic signed [12:0]       drive_value;
    logic                     direction;
    logic [15:0]              step_frequency;
    logic                     pulse_on;

    modport source (
        output valid, position, drive_value, direction, step_frequency, pulse_on,
        input  ready
    );
    modport sink (
        input  valid, position, drive_value, direction, step_frequency, pulse_on,
        output ready
    );
endinterface

### rtl/core/apsrd_cfg_if.sv
interface apsrd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [apsrd_pkg::REG_IW-1:0]  index;
    logic [31:0]                   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/angle_pid_step_rate_drive.sv
// Angle PID step-rate drive.
// The tick channel carries one control tick: angle sample, elapsed time,
// target, enable and an optional speed request. The result channel returns
// one word per tick: folded position, clamped drive, direction, step
// frequency and pulse enable. The cfg channel writes gains, limits and
// sensor options; it is always ready and is meant to be used while idle.
// Each tick runs up to ten operations in turn on the shared shift-and-add
// multiplier and restoring divider, which retire one bit per cycle.
// A saturated integral, zero elapsed time or a position outside the ramps
// skips an operation and shortens the tick.
// A new tick is taken once the previous one has been handed to the result
// register, so a finished word may wait while the next tick is worked on.
// If the receiver stalls, the word is held and the next tick waits in the
// final state until the result register is free.
// Reset clears the integral, the last error, the sequencer and the result
// valid, and loads the configuration defaults.
module angle_pid_step_rate_drive #(
    parameter int SAMPLE_BITS = apsrd_pkg::SAMPLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    apsrd_tick_if.sink     tick,
    apsrd_result_if.source result,
    apsrd_cfg_if.sink      cfg
);
    import apsrd_pkg::*;

    localparam int FW = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 2;
    localparam int EW = FW + 1;
    localparam int PW = SAMPLE_BITS + 1;
    localparam int TW = 12;
    localparam int QW = EW + 12;
    localparam int VW = QW + 2;
    localparam int SDW = EW + 17;
    localparam int FULL_I = 1 << SAMPLE_BITS;
    localparam logic signed [FW-1:0] FULL_S = FW'(FULL_I);
    localparam logic signed [FW-1:0] HALF_S = FW'(FULL_I / 2);

    // Configuration registers.
    logic signed [31:0] gp_reg, gi_reg, gd_reg;
    logic [11:0]        dl_reg;
    logic [9:0]         tm_reg, zo_reg;
    logic               srev_reg, mrev_reg;

    // Sequencer and state.
    state_t               state_reg, state_next;
    logic                 launched_reg, launched_next;
    logic signed [EW-1:0] last_e_reg;
    logic signed [47:0]   ei_reg;

    // Per-tick working registers.
    logic signed [FW-1:0]  p_reg;
    logic signed [EW-1:0]  e_reg;
    logic [19:0]           el_reg;
    logic                  en_reg;
    logic [TW-1:0]         t_reg, lo_reg, hi_reg, s_reg;
    logic [QW-1:0]         tmp_reg;
    logic signed [24:0]    si_reg;
    logic signed [SDW-1:0] sd_reg;
    logic signed [63:0]    acc_reg;

    // Result register.
    logic                  out_valid_reg;
    logic signed [PW-1:0]  pos_o_reg;
    logic signed [12:0]    drv_o_reg;
    logic                  dir_o_reg;
    logic [15:0]           freq_o_reg;
    logic                  pulse_o_reg;

    alu_req_t areq;
    alu_rsp_t arsp;

    logic                  tick_acc, op_done, run_op, out_load;
    logic                  si_skip, sd_skip, shape_skip;
    state_t                after_op;
    logic [SAMPLE_BITS-1:0] rd;
    logic signed [FW-1:0]  fa, fold_p;
    logic [11:0]           lim_c, t_c;
    logic [12:0]           rq_mag;
    logic signed [EW-1:0]  err_c, p_ext, tms, m1_s;
    logic [EW-1:0]         e_mag;
    region_t               region;
    logic [TW-1:0]         m2;
    logic [ALU_BW-1:0]     kdiv;
    logic [QW-1:0]         q_sh;
    logic signed [VW-1:0]  v_s;
    logic [VW-1:0]         v_mag;
    logic [TW-1:0]         s_c;
    logic [47:0]           ei_mag;
    logic signed [EW:0]    d_s;
    logic [EW-1:0]         d_mag;
    logic signed [63:0]    ep_s, sum_s;
    logic [24:0]           si_mag;
    logic [SDW-1:0]        sd_mag;
    logic [31:0]           gp_mag, gi_mag, gd_mag;
    logic signed [63:0]    term_s, base_s, acc_c;
    logic                  term_neg;
    logic signed [31:0]    u_q, sl, drv32;
    logic signed [12:0]    drv_c, spd_c;
    logic [12:0]           spd_mag;
    logic [15:0]           freq_c;

    apsrd_serial_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    assign tick_acc    = tick.valid && tick.ready;
    assign tick.ready  = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign op_done     = launched_reg && arsp.done;

    // Fold the sample, shape the speed target and form the error.
    always_comb
    begin
        rd = srev_reg ? ~tick.angle_sample : tick.angle_sample;
        fa = $signed(FW'(rd)) - $signed(FW'(zo_reg));
        if (fa < -HALF_S)
        begin
            fa = fa + FULL_S;
        end
        fold_p = (fa > HALF_S) ? (FULL_S - fa) : fa;
        lim_c  = (dl_reg < DRIVE_FLOOR) ? DRIVE_FLOOR : dl_reg;
        rq_mag = tick.requested_speed[12] ? (~tick.requested_speed + 13'd1)
                                          : tick.requested_speed;
        if (!tick.smart_move)
        begin
            t_c = lim_c;
        end
        else if (rq_mag < {1'b0, DRIVE_FLOOR})
        begin
            t_c = DRIVE_FLOOR;
        end
        else if (rq_mag > {1'b0, lim_c})
        begin
            t_c = lim_c;
        end
        else
        begin
            t_c = rq_mag[11:0];
        end
        err_c = EW'(tick.target_position) - EW'(fold_p);
    end

    // Ramp region and operands of the speed limit shaping.
    always_comb
    begin
        p_ext = EW'(p_reg);
        tms   = $signed({{(EW-10){1'b0}}, tm_reg}) - $signed(EW'(10));
        if (p_ext >= 0 && p_ext <= 20)
        begin
            region = R_LOW;
            m1_s   = p_ext;
            m2     = hi_reg - lo_reg;
            kdiv   = ALU_BW'(20);
        end
        else if (p_ext > 20 && p_ext <= 80)
        begin
            region = R_MID;
            m1_s   = p_ext - $signed(EW'(20));
            m2     = t_reg - hi_reg;
            kdiv   = ALU_BW'(60);
        end
        else if (p_ext >= tms)
        begin
            region = R_TOP;
            m1_s   = p_ext - tms;
            m2     = t_reg - DRIVE_FLOOR;
            kdiv   = ALU_BW'(10);
        end
        else
        begin
            region = R_NONE;
            m1_s   = '0;
            m2     = '0;
            kdiv   = ALU_BW'(10);
        end
        q_sh = arsp.value[QW-1:0];
        unique case (region)
            R_LOW:   v_s = $signed(VW'(lo_reg)) + $signed(VW'(q_sh));
            R_MID:   v_s = $signed(VW'(hi_reg)) + $signed(VW'(q_sh));
            R_TOP:   v_s = $signed(VW'(t_reg)) - $signed(VW'(q_sh));
            default: v_s = $signed(VW'(t_reg));
        endcase
        v_mag = v_s[VW-1] ? VW'(-v_s) : VW'(v_s);
        if (v_mag < VW'(DRIVE_FLOOR))
        begin
            s_c = DRIVE_FLOOR;
        end
        else if (v_mag > VW'(t_reg))
        begin
            s_c = t_reg;
        end
        else
        begin
            s_c = v_mag[TW-1:0];
        end
    end

    // PID arithmetic around the serial unit results.
    always_comb
    begin
        e_mag  = e_reg[EW-1] ? EW'(-e_reg) : EW'(e_reg);
        ei_mag = ei_reg[47] ? 48'(-ei_reg) : 48'(ei_reg);
        d_s    = (EW+1)'(e_reg) - (EW+1)'(last_e_reg);
        d_mag  = d_s[EW] ? EW'(-d_s) : EW'(d_s);
        si_mag = si_reg[24] ? 25'(-si_reg) : 25'(si_reg);
        sd_mag = sd_reg[SDW-1] ? SDW'(-sd_reg) : SDW'(sd_reg);
        gp_mag = gp_reg[31] ? 32'(-gp_reg) : 32'(gp_reg);
        gi_mag = gi_reg[31] ? 32'(-gi_reg) : 32'(gi_reg);
        gd_mag = gd_reg[31] ? 32'(-gd_reg) : 32'(gd_reg);

        // Saturating integral update.
        ep_s  = e_reg[EW-1] ? -$signed(arsp.value) : $signed(arsp.value);
        sum_s = 64'(ei_reg) + ep_s;
        if (sum_s > INT_MAX)
        begin
            sum_s = INT_MAX;
        end
        else if (sum_s < INT_MIN)
        begin
            sum_s = INT_MIN;
        end

        // Gain terms accumulate in Q32.32.
        if (state_reg == S_P_MUL)
        begin
            term_s   = $signed({arsp.value[47:0], 16'b0});
            term_neg = gp_reg[31] ^ e_reg[EW-1];
            base_s   = '0;
        end
        else if (state_reg == S_I_MUL)
        begin
            term_s   = $signed(arsp.value);
            term_neg = gi_reg[31] ^ si_reg[24];
            base_s   = acc_reg;
        end
        else
        begin
            term_s   = $signed(arsp.value);
            term_neg = gd_reg[31] ^ sd_reg[SDW-1];
            base_s   = acc_reg;
        end
        acc_c = term_neg ? (base_s - term_s) : (base_s + term_s);

        // Integer part toward zero, limit, end stops, rate outputs.
        u_q = acc_reg[63:32];
        if (acc_reg[63] && (acc_reg[31:0] != 32'd0))
        begin
            u_q = u_q + 32'sd1;
        end
        sl = $signed({20'b0, s_reg});
        if (u_q > sl)
        begin
            drv32 = sl;
        end
        else if (u_q < -sl)
        begin
            drv32 = -sl;
        end
        else
        begin
            drv32 = u_q;
        end
        drv_c = drv32[12:0];
        if (drv_c > 13'sd0)
        begin
            if (p_reg > $signed(FW'(tm_reg)))
            begin
                drv_c = '0;
            end
        end
        else if (p_reg < 0)
        begin
            drv_c = '0;
        end
        spd_c   = mrev_reg ? -drv_c : drv_c;
        spd_mag = spd_c[12] ? 13'(-spd_c) : 13'(spd_c);
        freq_c  = {spd_mag[12:0], 3'b0} + {2'b0, spd_mag, 1'b0};
    end

    // Sequencer: next state and serial unit requests.
    always_comb
    begin
        state_next    = state_reg;
        launched_next = launched_reg;
        areq          = '0;
        run_op        = 1'b0;
        after_op      = S_IDLE;
        si_skip       = 1'b0;
        sd_skip       = 1'b0;
        shape_skip    = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick.valid)
                begin
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                run_op      = 1'b1;
                after_op    = S_DIV_B;
                areq.is_div = 1'b1;
                areq.a      = ALU_AW'(t_reg);
                areq.b      = ALU_BW'(10);
                areq.nbits  = ALU_CW'(TW);
            end
            S_DIV_B:
            begin
                run_op      = 1'b1;
                after_op    = S_SHAPE_MUL;
                areq.is_div = 1'b1;
                areq.a      = ALU_AW'(t_reg);
                areq.b      = ALU_BW'(3);
                areq.nbits  = ALU_CW'(TW);
            end
            S_SHAPE_MUL:
            begin
                if (region == R_NONE)
                begin
                    shape_skip = 1'b1;
                    state_next = S_INT_MUL;
                end
                else
                begin
                    run_op     = 1'b1;
                    after_op   = S_SHAPE_DIV;
                    areq.a     = ALU_AW'(m2);
                    areq.b     = ALU_BW'(EW'(m1_s));
                    areq.nbits = ALU_CW'(EW);
                end
            end
            S_SHAPE_DIV:
            begin
                run_op      = 1'b1;
                after_op    = S_INT_MUL;
                areq.is_div = 1'b1;
                areq.a      = ALU_AW'(tmp_reg);
                areq.b      = kdiv;
                areq.nbits  = ALU_CW'(QW);
            end
            S_INT_MUL:
            begin
                run_op     = 1'b1;
                after_op   = S_SI_DIV;
                areq.a     = ALU_AW'(el_reg);
                areq.b     = ALU_BW'(e_mag);
                areq.nbits = ALU_CW'(EW);
            end
            S_SI_DIV:
            begin
                if (ei_reg >= I_SAT_POS || ei_reg <= I_SAT_NEG)
                begin
                    si_skip    = 1'b1;
                    state_next = S_SD_DIV;
                end
                else
                begin
                    run_op      = 1'b1;
                    after_op    = S_SD_DIV;
                    areq.is_div = 1'b1;
                    areq.a      = {ei_mag, 16'b0};
                    areq.b      = I_SCALE;
                    areq.nbits  = ALU_CW'(44);
                end
            end
            S_SD_DIV:
            begin
                if (el_reg == 20'd0)
                begin
                    sd_skip    = 1'b1;
                    state_next = S_P_MUL;
                end
                else
                begin
                    run_op      = 1'b1;
                    after_op    = S_P_MUL;
                    areq.is_div = 1'b1;
                    areq.a      = ALU_AW'({d_mag, 16'b0});
                    areq.b      = ALU_BW'(el_reg);
                    areq.nbits  = ALU_CW'(EW + 16);
                end
            end
            S_P_MUL:
            begin
                run_op     = 1'b1;
                after_op   = S_I_MUL;
                areq.a     = ALU_AW'(gp_mag);
                areq.b     = ALU_BW'(e_mag);
                areq.nbits = ALU_CW'(EW);
            end
            S_I_MUL:
            begin
                run_op     = 1'b1;
                after_op   = S_D_MUL;
                areq.a     = ALU_AW'(gi_mag);
                areq.b     = ALU_BW'(si_mag[23:0]);
                areq.nbits = ALU_CW'(24);
            end
            S_D_MUL:
            begin
                run_op     = 1'b1;
                after_op   = S_FINISH;
                areq.a     = ALU_AW'(gd_mag);
                areq.b     = ALU_BW'(sd_mag[SDW-2:0]);
                areq.nbits = ALU_CW'(EW + 16);
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (run_op)
        begin
            if (!launched_reg)
            begin
                areq.start    = 1'b1;
                launched_next = 1'b1;
            end
            else if (arsp.done)
            begin
                launched_next = 1'b0;
                state_next    = after_op;
            end
        end
    end

    // Control, state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            launched_reg  <= 1'b0;
            last_e_reg    <= '0;
            ei_reg        <= '0;
            out_valid_reg <= 1'b0;
            gp_reg        <= RST_GAIN_P;
            gi_reg        <= '0;
            gd_reg        <= '0;
            dl_reg        <= RST_DRIVE_LIMIT;
            tm_reg        <= RST_TRAVEL_MAX;
            zo_reg        <= '0;
            srev_reg      <= 1'b0;
            mrev_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            if (op_done && state_reg == S_INT_MUL)
            begin
                ei_reg <= sum_s[47:0];
            end
            if (sd_skip || (op_done && state_reg == S_SD_DIV))
            begin
                last_e_reg <= e_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_GAIN_P:      gp_reg   <= cfg.data;
                    REG_GAIN_I:      gi_reg   <= cfg.data;
                    REG_GAIN_D:      gd_reg   <= cfg.data;
                    REG_DRIVE_LIMIT: dl_reg   <= cfg.data[11:0];
                    REG_TRAVEL_MAX:  tm_reg   <= cfg.data[9:0];
                    REG_ZERO_OFFSET: zo_reg   <= cfg.data[9:0];
                    REG_SENSOR_REV:  srev_reg <= cfg.data[0];
                    REG_MOTOR_REV:   mrev_reg <= cfg.data[0];
                    default:         ;
                endcase
            end
        end
    end

    // Working and result words.
    always_ff @(posedge clk)
    begin
        if (tick_acc)
        begin
            p_reg  <= fold_p;
            e_reg  <= err_c;
            el_reg <= tick.elapsed_us;
            en_reg <= tick.drive_enable;
            t_reg  <= t_c;
        end
        if (op_done)
        begin
            unique case (state_reg)
                S_DIV_A:     lo_reg  <= arsp.value[TW-1:0];
                S_DIV_B:     hi_reg  <= arsp.value[TW-1:0];
                S_SHAPE_MUL: tmp_reg <= arsp.value[QW-1:0];
                S_SHAPE_DIV: s_reg   <= s_c;
                S_SI_DIV:
                begin
                    si_reg <= ei_reg[47] ? -$signed({1'b0, arsp.value[23:0]})
                                         : $signed({1'b0, arsp.value[23:0]});
                end
                S_SD_DIV:
                begin
                    sd_reg <= d_s[EW] ? -$signed({1'b0, arsp.value[SDW-2:0]})
                                      : $signed({1'b0, arsp.value[SDW-2:0]});
                end
                S_P_MUL, S_I_MUL, S_D_MUL: acc_reg <= acc_c;
                default: ;
            endcase
        end
        if (shape_skip)
        begin
            s_reg <= t_reg;
        end
        if (si_skip)
        begin
            si_reg <= ei_reg[47] ? -SI_SAT : SI_SAT;
        end
        if (sd_skip)
        begin
            sd_reg <= '0;
        end
        if (out_load)
        begin
            pos_o_reg   <= PW'(p_reg);
            drv_o_reg   <= drv_c;
            dir_o_reg   <= (spd_c > 13'sd0);
            freq_o_reg  <= freq_c;
            pulse_o_reg <= en_reg && (freq_c > FREQ_MIN);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.position       = pos_o_reg;
    assign result.drive_value    = drv_o_reg;
    assign result.direction      = dir_o_reg;
    assign result.step_frequency = freq_o_reg;
    assign result.pulse_on       = pulse_o_reg;

    // An accepted tick always starts the limit shaping.
    a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
        tick.valid && tick.ready |=> state_reg == S_DIV_A)
        else $error("tick accepted but sequencer did not start");

    // No serial operation is outstanding while idle.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !launched_reg)
        else $error("serial operation pending in idle");

    // The serial unit finishes only an operation that was launched.
    a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
        arsp.done |-> launched_reg)
        else $error("serial unit finished without a request");

    // Step frequency stays within ten times the largest drive.
    a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> freq_o_reg <= 16'd40950)
        else $error("step frequency out of range");

endmodule

### rtl/core/apsrd_serial_alu.sv
module apsrd_serial_alu (
    input  logic                clk,
    input  logic                rst_n,
    input  apsrd_pkg::alu_req_t req,
    output apsrd_pkg::alu_rsp_t rsp
);
    import apsrd_pkg::*;

    logic              busy_reg, busy_next;
    logic              div_reg, div_next;
    logic              done_reg, done_next;
    logic [ALU_CW-1:0] cnt_reg, cnt_next;
    logic [ALU_AW-1:0] opa_reg, opa_next;
    logic [ALU_BW-1:0] opb_reg, opb_next;
    logic [ALU_AW-1:0] acc_reg, acc_next;
    logic [ALU_BW-1:0] rem_reg, rem_next;
    logic [ALU_CW-1:0] cnt_dec;
    logic [ALU_BW:0]   rem_sh;
    logic [ALU_BW:0]   rem_sub;

    // One bit of the multiplier or one quotient bit per cycle.
    always_comb
    begin
        busy_next = busy_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        cnt_dec   = cnt_reg - 1'b1;
        rem_sh    = {rem_reg, opa_reg[cnt_dec[ALU_IW-1:0]]};
        rem_sub   = rem_sh - {1'b0, opb_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = req.is_div;
            cnt_next  = req.nbits;
            opa_next  = req.a;
            opb_next  = req.b;
            acc_next  = '0;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (div_reg)
            begin
                if (rem_sh >= {1'b0, opb_reg})
                begin
                    rem_next = rem_sub[ALU_BW-1:0];
                    acc_next = {acc_reg[ALU_AW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[ALU_BW-1:0];
                    acc_next = {acc_reg[ALU_AW-2:0], 1'b0};
                end
            end
            else
            begin
                if (opb_reg[0])
                begin
                    acc_next = acc_reg + opa_reg;
                end
                opa_next = {opa_reg[ALU_AW-2:0], 1'b0};
                opb_next = {1'b0, opb_reg[ALU_BW-1:1]};
            end
            cnt_next = cnt_dec;
            if (cnt_reg == ALU_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            div_reg  <= div_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and result shift registers.
    always_ff @(posedge clk)
    begin
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = acc_reg;

endmodule

### tb/angle_pid_step_rate_drive_test.sv
`timescale 1ns / 1ps

module angle_pid_step_rate_drive_test;
    import apsrd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #1 clk = ~clk;

    apsrd_tick_if   tick_ch ();
    apsrd_result_if result_ch ();
    apsrd_cfg_if    cfg_ch ();

    angle_pid_step_rate_drive dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // One control tick and one result word.
    typedef struct {
        logic [9:0]         angle;
        logic [19:0]        elapsed;
        logic signed [10:0] target;
        logic               enable;
        logic               smart;
        logic signed [12:0] speed;
    } tick_word_t;

    typedef struct packed {
        logic signed [10:0] position;
        logic signed [12:0] drive;
        logic               direction;
        logic [15:0]        frequency;
        logic               pulse;
    } drive_word_t;

    // Directed row: tick, plus an optional typed-in expected word.
    typedef struct {
        tick_word_t  word;
        bit          typed;
        drive_word_t want;
    } tick_row_t;

    // Controller copy: configuration and loop state.
    longint kp, ki, kd, limit_cfg, travel_top, offset_cfg;
    bit     sensor_flip, motor_flip;
    longint prev_error, integral_sum;

    drive_word_t expected_words[$];
    int  errors = 0;
    int  ticks_sent = 0;
    int  words_checked = 0;
    int  idle_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // Fold the raw sample into a signed position around the zero offset.
    function automatic longint fold_angle(logic [9:0] raw);
        longint r, a;
        r = raw;
        if (sensor_flip)
            r = 1023 - r;
        a = r - offset_cfg;
        if (a < -512)
            a += 1024;
        if (a > 512)
            a = 1024 - a;
        return a;
    endfunction

    // Speed limit ramps near both ends of travel.
    function automatic longint ramp_limit(longint p, longint t);
        longint lo_end, mid_end, v;
        lo_end = t / 10;
        mid_end = t / 3;
        if (p >= 0 && p <= 20)
            v = p * (mid_end - lo_end) / 20 + lo_end;
        else if (p > 20 && p <= 80)
            v = (p - 20) * (t - mid_end) / 60 + mid_end;
        else if (p >= travel_top - 10)
            v = (p - (travel_top - 10)) * (100 - t) / 10 + t;
        else
            v = t;
        if (v < 0)
            v = -v;
        return clip(v, 100, t);
    endfunction

    // One PID tick: updates the loop state and returns the drive word.
    function automatic drive_word_t pid_drive_step(tick_word_t w);
        drive_word_t o;
        longint p, el, t, s, e, si, sd, drv, spd, freq, lim, ispan;
        longint u_hi;
        logic signed [127:0] u;
        ispan = (longint'(1) <<< 47) - 1;
        p = fold_angle(w.angle);
        el = w.elapsed;
        lim = (limit_cfg < 100) ? 100 : limit_cfg;
        if (w.smart)
        begin
            t = (w.speed < 0) ? -longint'(w.speed) : longint'(w.speed);
            t = clip(t, 100, lim);
        end
        else
            t = lim;
        s = ramp_limit(p, t);
        e = longint'(w.target) - p;
        integral_sum = clip(integral_sum + e * el, -ispan - 1, ispan);
        if (integral_sum >= 255000000)
            si = 255 * 65536;
        else if (integral_sum <= -255000000)
            si = -255 * 65536;
        else
            si = integral_sum * 65536 / 1000000;
        sd = (el != 0) ? (e - prev_error) * 65536 / el : 0;
        prev_error = e;
        // Wide sum so the Q32.32 products cannot wrap.
        u = 128'(kp) * 128'(e) * 65536 + 128'(ki) * 128'(si) + 128'(kd) * 128'(sd);
        u = u / (128'sd1 <<< 32);
        u_hi = (u > 128'(s)) ? s : ((u < -128'(s)) ? -s : longint'(u));
        drv = u_hi;
        if (drv > 0)
        begin
            if (p > travel_top)
                drv = 0;
        end
        else if (p < 0)
            drv = 0;
        spd = motor_flip ? -drv : drv;
        freq = ((spd < 0) ? -spd : spd) * 10;
        o.position = 11'(p);
        o.drive = 13'(drv);
        o.direction = spd > 0;
        o.frequency = 16'(freq);
        o.pulse = w.enable && freq > 40;
        return o;
    endfunction

    task automatic reset_model();
        kp = 65536; ki = 0; kd = 0;
        limit_cfg = 1000; travel_top = 512; offset_cfg = 0;
        sensor_flip = 0; motor_flip = 0;
        prev_error = 0; integral_sum = 0;
    endtask

    // Register write on the cfg channel; model copy updated on acceptance.
    // The valid stays high so writes can follow back to back; the next tick
    // drops it.
    task automatic write_reg(logic [REG_IW-1:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_GAIN_P:      kp = longint'(signed'(val));
            REG_GAIN_I:      ki = longint'(signed'(val));
            REG_GAIN_D:      kd = longint'(signed'(val));
            REG_DRIVE_LIMIT: limit_cfg = val[11:0];
            REG_TRAVEL_MAX:  travel_top = val[9:0];
            REG_ZERO_OFFSET: offset_cfg = val[9:0];
            REG_SENSOR_REV:  sensor_flip = val[0];
            REG_MOTOR_REV:   motor_flip = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                             logic [11:0] lim, logic [9:0] top, logic [9:0] off,
                             bit sflip, bit mflip);
        write_reg(REG_GAIN_P, p);
        write_reg(REG_GAIN_I, i);
        write_reg(REG_GAIN_D, d);
        write_reg(REG_DRIVE_LIMIT, {20'd0, lim});
        write_reg(REG_TRAVEL_MAX, {22'd0, top});
        write_reg(REG_ZERO_OFFSET, {22'd0, off});
        write_reg(REG_SENSOR_REV, {31'd0, sflip});
        write_reg(REG_MOTOR_REV, {31'd0, mflip});
    endtask

    // Wait for every outstanding word, then let the block settle.
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Drive one tick with an optional random idle gap before it.
    task automatic send_tick(tick_word_t w);
        cfg_ch.valid <= 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.angle_sample <= w.angle;
        tick_ch.elapsed_us <= w.elapsed;
        tick_ch.target_position <= w.target;
        tick_ch.drive_enable <= w.enable;
        tick_ch.smart_move <= w.smart;
        tick_ch.requested_speed <= w.speed;
        do
            @(posedge clk);
        while (!tick_ch.ready);
        expected_words.push_back(pid_drive_step(w));
        ticks_sent++;
    endtask

    function automatic tick_word_t random_tick();
        tick_word_t w;
        w.angle = 10'($urandom);
        case ($urandom_range(3))
            0: w.elapsed = 20'($urandom);
            1: w.elapsed = 20'($urandom_range(0, 3));
            default: w.elapsed = 20'($urandom_range(100, 5000));
        endcase
        w.target = 11'($urandom_range(0, 1024) - 512);
        w.enable = $urandom_range(1);
        w.smart = $urandom_range(1);
        w.speed = 13'($urandom_range(0, 8000) - 4000);
        return w;
    endfunction

    // Receiver: random stall, compare each word with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word position=%0d drive=%0d", $time,
                             result_ch.position, result_ch.drive_value);
                    errors++;
                end
                else
                begin
                    drive_word_t x;
                    x = expected_words.pop_front();
                    words_checked++;
                    if (result_ch.position !== x.position ||
                        result_ch.drive_value !== x.drive ||
                        result_ch.direction !== x.direction ||
                        result_ch.step_frequency !== x.frequency ||
                        result_ch.pulse_on !== x.pulse)
                    begin
                        $display("%0t: mismatch expected pos=%0d drv=%0d dir=%0b freq=%0d pulse=%0b",
                                 $time, x.position, x.drive, x.direction, x.frequency, x.pulse);
                        $display("%0t:          actual   pos=%0d drv=%0d dir=%0b freq=%0d pulse=%0b",
                                 $time, result_ch.position, result_ch.drive_value,
                                 result_ch.direction, result_ch.step_frequency,
                                 result_ch.pulse_on);
                        errors++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no handshake anywhere.
    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    tick_row_t rows[$];

    function automatic tick_row_t make_row(logic [9:0] a, logic [19:0] el,
                                           logic signed [10:0] tg, bit en, bit sm,
                                           logic signed [12:0] sp);
        tick_row_t r;
        r.word.angle = a; r.word.elapsed = el; r.word.target = tg;
        r.word.enable = en; r.word.smart = sm; r.word.speed = sp;
        r.typed = 0;
        return r;
    endfunction

    initial
    begin
        tick_word_t w;
        tick_row_t r;
        drive_word_t typed_copy;
        tick_ch.valid = 1'b0;
        tick_ch.angle_sample = '0;
        tick_ch.elapsed_us = '0;
        tick_ch.target_position = '0;
        tick_ch.drive_enable = 1'b0;
        tick_ch.smart_move = 1'b0;
        tick_ch.requested_speed = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. First row after reset: position 0, target 0 gives zero drive.
        r = make_row(10'd0, 20'd0, 11'sd0, 1'b1, 1'b0, 13'sd0);
        r.typed = 1;
        r.want = '{11'sd0, 13'sd0, 1'b0, 16'd0, 1'b0};
        rows.push_back(r);
        // Target above at mid travel with unit gain: the drive equals the error.
        r = make_row(10'd200, 20'd0, 11'sd512, 1'b1, 1'b0, 13'sd0);
        r.typed = 1;
        r.want = '{11'sd200, 13'sd312, 1'b1, 16'd3120, 1'b1};
        rows.push_back(r);
        rows.push_back(make_row(10'd1023, 20'hFFFFF, -11'sd512, 1'b1, 1'b0, 13'sd0));
        rows.push_back(make_row(10'd512, 20'd1, 11'sd512, 1'b0, 1'b1, 13'sd4000));
        rows.push_back(make_row(10'd513, 20'd1000, -11'sd512, 1'b1, 1'b1, -13'sd4000));
        rows.push_back(make_row(10'd10, 20'd50, 11'sd400, 1'b1, 1'b1, 13'sd50));
        rows.push_back(make_row(10'd50, 20'd0, 11'sd300, 1'b1, 1'b0, 13'sd0));
        rows.push_back(make_row(10'd505, 20'd100, 11'sd512, 1'b1, 1'b0, 13'sd0));
        rows.push_back(make_row(10'd1000, 20'd100, 11'sd0, 1'b1, 1'b0, 13'sd0));
        rows.push_back(make_row(10'd3, 20'd7, 11'sd4, 1'b1, 1'b1, -13'sd1));
        rows.push_back(make_row(10'd700, 20'd123, 11'sd100, 1'b1, 1'b1, 13'sd4095));
        rows.push_back(make_row(10'd300, 20'd999, -11'sd1, 1'b1, 1'b1, -13'sd4096));
        foreach (rows[k])
        begin
            send_tick(rows[k].word);
            if (rows[k].typed)
            begin
                typed_copy = expected_words[expected_words.size() - 1];
                expected_words[expected_words.size() - 1] = rows[k].want;
                if (typed_copy !== rows[k].want)
                    $display("%0t: note: predictor differs on directed row %0d", $time, k);
            end
        end
        drain();

        // Extremes of configuration, with integral and derivative active.
        write_all(32'h7FFF_FFFF, 32'h0000_1000, 32'h8000_0000, 12'd4000, 10'd11,
                  10'd1023, 1'b1, 1'b1);
        rows.delete();
        for (int k = 0; k < 8; k++)
            send_tick(random_tick());
        drain();
        write_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 12'd100, 10'd512,
                  10'd0, 1'b0, 1'b0);
        for (int k = 0; k < 6; k++)
            send_tick(random_tick());
        drain();
        // Limit below the floor and an unknown register index.
        write_all(32'h0002_0000, 32'h0000_0100, 32'h0000_0800, 12'd40, 10'd300,
                  10'd512, 1'b0, 1'b1);
        write_reg(4'd12, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++)
            send_tick(random_tick());
        // Hold off until the pipeline is empty.
        drain();

        // Random phases with varied idling and configuration.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_all($urandom_range(0, 4) * 32'h0000_8000 - 32'h0001_0000,
                      $urandom_range(0, 64), $urandom_range(0, 1) ? $urandom : 32'd0,
                      12'($urandom_range(100, 4000)), 10'($urandom_range(11, 512)),
                      10'($urandom), $urandom_range(1), $urandom_range(1));
            for (int k = 0; k < 192; k++)
                send_tick(random_tick());
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Covered %0d ticks and %0d checked words over 8 random phases,", ticks_sent,
                 words_checked);
        $display("config extremes, reversal options and end-stop cases.");
        if (errors == 0 && expected_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
rtl/core/apsrd_pkg.sv
rtl/core/apsrd_tick_if.sv
rtl/core/apsrd_result_if.sv
rtl/core/apsrd_cfg_if.sv
rtl/core/apsrd_serial_alu.sv
rtl/core/angle_pid_step_rate_drive.sv
tb/angle_pid_step_rate_drive_test.sv
